>>> design/fsync_pkg.sv
// ----------------------------------------------------------------------------
// fsync_pkg
// Shared types and constants of the packet frame synchroniser.
// ----------------------------------------------------------------------------
package fsync_pkg;

  typedef enum logic [1:0] {
    MODE_SEARCH  = 2'd0,
    MODE_CONFIRM = 2'd1,
    MODE_SYNCED  = 2'd2,
    MODE_LOSS    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_DELIMITER     = 2'd0,
    REG_FOOTER_FIRST  = 2'd1,
    REG_FOOTER_SECOND = 2'd2,
    REG_BAD_LIMIT     = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] DELIMITER_RST     = 8'h24;
  localparam logic [7:0] FOOTER_FIRST_RST  = 8'h0D;
  localparam logic [7:0] FOOTER_SECOND_RST = 8'h0A;
  localparam logic [3:0] BAD_LIMIT_RST     = 4'd2;
  localparam logic [3:0] BAD_COUNT_MAX     = 4'd15;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [7:0] footer_first;
    logic [7:0] footer_second;
    logic [3:0] bad_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic  emit;
    mode_t mode;
  } job_t;

endpackage

>>> design/fsync_if.sv
// ----------------------------------------------------------------------------
// fsync_if
// Valid/ready channels of the packet frame synchroniser.
// ----------------------------------------------------------------------------
interface fsync_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface fsync_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_packet;
  logic       last;
  logic [1:0] sync_state;

  modport source (output valid, output out_byte, output is_packet, output last,
                  output sync_state, input ready);
  modport sink (input valid, input out_byte, input is_packet, input last,
                input sync_state, output ready);
endinterface

interface fsync_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/fsync_ctrl.sv
// ----------------------------------------------------------------------------
// fsync_ctrl
// Window tracking, delimiter search, byte dropping and the sync state machine.
// ----------------------------------------------------------------------------
module fsync_ctrl
  import fsync_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cfg_regs_t                       regs,
  fsync_byte_if.sink                      data,
  input  logic                            job_free,
  output logic                            wr_en,
  output logic                            wr_bank,
  output logic [$clog2(PACKET_BYTES)-1:0] wr_idx,
  output logic [7:0]                      wr_data,
  output logic                            job_start,
  output job_t                            job
);

  localparam int unsigned IW = $clog2(PACKET_BYTES);
  localparam logic [IW-1:0] LAST_IDX = IW'(PACKET_BYTES - 1);
  localparam logic [IW-1:0] FOOT_IDX = IW'(PACKET_BYTES - 2);

  logic [IW-1:0] fill;
  logic [IW-1:0] delim_pos;
  logic [IW-1:0] skip;
  mode_t         mode;
  logic [3:0]    bad_count;
  logic          bank;
  logic [7:0]    head_byte;
  logic [7:0]    foot_byte;

  logic          skipping;
  logic          completing;
  logic          accept;
  logic [7:0]    b;
  logic [IW-1:0] delim_pos_next;
  logic          win_ok;
  logic [3:0]    bad_inc;
  mode_t         mode_next;
  logic [3:0]    bad_count_next;
  logic [IW-1:0] skip_next;
  logic          emit;

  assign b          = data.data_byte;
  assign skipping   = (skip != '0);
  assign completing = !skipping && (fill == LAST_IDX);
  assign data.ready = !completing || job_free;
  assign accept     = data.valid && data.ready;

  assign delim_pos_next = (fill != '0 && delim_pos == '0 && b == regs.delimiter) ?
                          fill : delim_pos;
  assign win_ok = (head_byte == regs.delimiter) && (foot_byte == regs.footer_first) &&
                  (b == regs.footer_second);
  assign bad_inc = (bad_count < BAD_COUNT_MAX) ? bad_count + 4'd1 : bad_count;

  always_comb begin
    mode_next      = mode;
    bad_count_next = bad_count;
    skip_next      = '0;
    emit           = 1'b0;
    unique case (mode)
      MODE_SEARCH: begin
        if (win_ok) begin
          mode_next = MODE_CONFIRM;
        end else if (delim_pos_next != '0) begin
          skip_next = delim_pos_next;
          mode_next = MODE_CONFIRM;
        end
      end
      MODE_CONFIRM: begin
        if (win_ok) begin
          mode_next = MODE_SYNCED;
          emit      = 1'b1;
        end else begin
          mode_next = MODE_SEARCH;
        end
      end
      MODE_SYNCED: begin
        if (win_ok) begin
          emit = 1'b1;
        end else begin
          bad_count_next = 4'd1;
          mode_next      = MODE_LOSS;
        end
      end
      MODE_LOSS: begin
        if (win_ok) begin
          mode_next = MODE_SYNCED;
        end else begin
          bad_count_next = bad_inc;
          if (bad_inc >= regs.bad_limit) begin
            mode_next = MODE_SEARCH;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      delim_pos <= '0;
      skip      <= '0;
      mode      <= MODE_SEARCH;
      bad_count <= '0;
      bank      <= 1'b0;
    end else if (accept) begin
      if (skipping) begin
        skip <= skip - 1'b1;
      end else if (completing) begin
        fill      <= '0;
        delim_pos <= '0;
        skip      <= skip_next;
        mode      <= mode_next;
        bad_count <= bad_count_next;
        bank      <= ~bank;
      end else begin
        fill      <= fill + 1'b1;
        delim_pos <= delim_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !skipping && fill == '0) begin
      head_byte <= b;
    end
    if (accept && !skipping && fill == FOOT_IDX) begin
      foot_byte <= b;
    end
  end

  assign wr_en     = accept && !skipping;
  assign wr_bank   = bank;
  assign wr_idx    = fill;
  assign wr_data   = b;
  assign job_start = accept && completing;
  assign job       = '{emit: emit, mode: mode_next};

  a_skip_only_confirm: assert property (@(posedge clk) disable iff (rst)
    skip != '0 |-> mode == MODE_CONFIRM)
    else $error("bytes are being dropped outside the confirming state");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (rst)
    !data.ready |-> !job_free && completing)
    else $error("input stalled without a pending window");

  a_window_restart: assert property (@(posedge clk) disable iff (rst)
    job_start |=> fill == '0 && delim_pos == '0)
    else $error("window position not cleared after completion");

endmodule

>>> design/fsync_emit.sv
// ----------------------------------------------------------------------------
// fsync_emit
// Two-bank window memory and the read pipeline that delivers the results.
// ----------------------------------------------------------------------------
module fsync_emit
  import fsync_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic                            wr_bank,
  input  logic [$clog2(PACKET_BYTES)-1:0] wr_idx,
  input  logic [7:0]                      wr_data,
  input  logic                            job_start,
  input  job_t                            job,
  output logic                            job_free,
  fsync_res_if.source                     result
);

  localparam int unsigned IW    = $clog2(PACKET_BYTES);
  localparam int unsigned AW    = IW + 1;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam logic [IW-1:0] LAST_IDX = IW'(PACKET_BYTES - 1);

  logic [7:0]    mem [DEPTH];

  logic          job_valid;
  logic          job_emit;
  mode_t         job_mode;
  logic          rd_bank;
  logic [IW-1:0] gen_idx;

  logic          p1_valid;
  logic          p1_pkt;
  logic          p1_last;
  mode_t         p1_mode;
  logic [7:0]    mem_q;

  logic          out_free;
  logic          p1_load_ok;
  logic          p1_move;
  logic          gen_adv;
  logic          gen_last;

  assign out_free   = !result.valid || result.ready;
  assign p1_load_ok = !p1_valid || out_free;
  assign p1_move    = p1_valid && out_free;
  assign gen_adv    = job_valid && p1_load_ok;
  assign gen_last   = !job_emit || (gen_idx == LAST_IDX);
  assign job_free   = !job_valid || (gen_adv && gen_last);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_bank, wr_idx}] <= wr_data;
    end
    if (gen_adv) begin
      mem_q <= mem[{rd_bank, gen_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid    <= 1'b0;
      gen_idx      <= '0;
      p1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (job_start) begin
        job_valid <= 1'b1;
        gen_idx   <= '0;
      end else if (gen_adv) begin
        if (gen_last) begin
          job_valid <= 1'b0;
        end
        gen_idx <= gen_idx + 1'b1;
      end
      if (p1_load_ok) begin
        p1_valid <= gen_adv;
      end
      if (out_free) begin
        result.valid <= p1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_start) begin
      job_emit <= job.emit;
      job_mode <= job.mode;
      rd_bank  <= wr_bank;
    end
    if (gen_adv) begin
      p1_pkt  <= job_emit;
      p1_last <= gen_last;
      p1_mode <= job_mode;
    end
    if (p1_move) begin
      result.out_byte   <= p1_pkt ? mem_q : 8'd0;
      result.is_packet  <= p1_pkt;
      result.last       <= p1_last;
      result.sync_state <= p1_mode;
    end
  end

  a_job_interlock: assert property (@(posedge clk) disable iff (rst)
    job_start |-> job_free)
    else $error("new window completed while the previous one is still being read");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.is_packet |-> result.out_byte == 8'd0 && result.last)
    else $error("status result carries data or is not last");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    p1_valid && !p1_pkt |-> p1_last)
    else $error("status request not marked last");

endmodule

>>> design/packet_frame_synchronizer_core.sv
// ----------------------------------------------------------------------------
// packet_frame_synchronizer_core
// Fixed-length frame synchroniser with hysteresis over a byte stream.
//
//   Port    Direction  Carries
//   cfg     sink       register index and write data
//   data    sink       data_byte, one stream byte per request
//   result  source     out_byte, is_packet, last, sync_state
//
// One byte is taken in every cycle; a window's completing byte waits while
// the previous window is still being read out. A completed window is read
// out of a two-bank memory one entry per cycle unless the result stalls, so
// a window of bytes is delivered while the next one fills. Reset is
// synchronous and needs no clearing pass. A stalled result holds its register.
// ----------------------------------------------------------------------------
module packet_frame_synchronizer_core
  import fsync_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  fsync_cfg_if.sink   cfg,
  fsync_byte_if.sink  data,
  fsync_res_if.source result
);

  localparam int unsigned IW = $clog2(PACKET_BYTES);

  cfg_regs_t     regs;
  logic          wr_en;
  logic          wr_bank;
  logic [IW-1:0] wr_idx;
  logic [7:0]    wr_data;
  logic          job_start;
  job_t          job;
  logic          job_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.delimiter     <= DELIMITER_RST;
      regs.footer_first  <= FOOTER_FIRST_RST;
      regs.footer_second <= FOOTER_SECOND_RST;
      regs.bad_limit     <= BAD_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_DELIMITER:     regs.delimiter     <= cfg.data;
        REG_FOOTER_FIRST:  regs.footer_first  <= cfg.data;
        REG_FOOTER_SECOND: regs.footer_second <= cfg.data;
        REG_BAD_LIMIT:     regs.bad_limit     <= cfg.data[3:0];
      endcase
    end
  end

  fsync_ctrl #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .data      (data),
    .job_free  (job_free),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .job_start (job_start),
    .job       (job)
  );

  fsync_emit #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .job_start (job_start),
    .job       (job),
    .job_free  (job_free),
    .result    (result)
  );

endmodule
